[hdl/rbfk_pkg.sv]
package rbfk_pkg;

   // Store geometry and field widths.
   localparam int MAX_SAMPLES  = 256;
   localparam int MAX_FEATURES = 16;
   localparam int FEATURE_BITS = 16;
   localparam int SAMPLE_BITS  = 8;
   localparam int FIDX_BITS    = 4;
   localparam int ADDR_BITS    = SAMPLE_BITS + FIDX_BITS;
   localparam int COUNT_BITS   = 5;
   localparam int GAMMA_BITS   = 24;
   localparam int KERNEL_BITS  = 17;

   // Configuration register indexes.
   localparam logic [7:0] CSR_GAMMA         = 8'd0;
   localparam logic [7:0] CSR_FEATURE_COUNT = 8'd1;

   // Item kinds carried in tuser.
   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_COMPUTE = 1'b1;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   // exp(-2^(b-16)) in Q0.30, rounded to nearest.
   function automatic logic [29:0] exp_bit(input logic [4:0] b);
      logic [29:0] v;
      case (b)
         5'd0:  v = 30'd1073725440;
         5'd1:  v = 30'd1073709056;
         5'd2:  v = 30'd1073676290;
         5'd3:  v = 30'd1073610760;
         5'd4:  v = 30'd1073479712;
         5'd5:  v = 30'd1073217664;
         5'd6:  v = 30'd1072693760;
         5'd7:  v = 30'd1071646719;
         5'd8:  v = 30'd1069555701;
         5'd9:  v = 30'd1065385899;
         5'd10: v = 30'd1057095000;
         5'd11: v = 30'd1040706261;
         5'd12: v = 30'd1008687096;
         5'd13: v = 30'd947573834;
         5'd14: v = 30'd836230973;
         5'd15: v = 30'd651257337;
         5'd16: v = 30'd395007542;
         5'd17: v = 30'd145315154;
         5'd18: v = 30'd19666268;
         5'd19: v = 30'd360200;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

[hdl/rbf_kernel_pair.sv]
// Channel | Direction | Handshake             | Payload
// req     | in        | req_tvalid/req_tready | tuser kind, tdata load/pair fields
// rsp     | out       | rsp_tvalid/rsp_tready | tdata row, column, kernel value
// csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// A pair result is valid after these steps from the accepting edge: one sample-memory read
// pair per feature, a drain of the square pipeline, two partial products and a range check
// for gamma, twenty steps of the exponent multiplier and a register for the result. The next
// transfer can be taken once the result is registered.
// Reset clears control state and sets gamma to 1.0 and feature_count to 16.
// While a pair is in work req_tready is low; transfers are taken while a result waits,
// and a second pair then holds in its last step until the waiting result is taken.
module rbf_kernel_pair (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // action
   input  logic [39:0] req_tdata,   // sample_index, feature_index, partner_index, feature_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // row_out, col_out, kernel_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [23:0] csr_data
);
   import rbfk_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_DRAIN, S_MUL_LO, S_MUL_HI, S_CHECK, S_EXP, S_DONE
   } state_type;

   state_type state_ff;

   logic [GAMMA_BITS-1:0]   gamma_ff;
   logic [COUNT_BITS-1:0]   fcount_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   k_ff;
   logic [SAMPLE_BITS-1:0]  row_ff, col_ff;
   logic                    v1_ff, v2_ff;
   logic [31:0]             sq_ff;
   logic [35:0]             sum_ff;
   logic [41:0]             plo_ff, phi_ff;
   logic                    big_ff;
   logic [19:0]             x_ff;
   logic [30:0]             acc_ff;
   logic [4:0]              b_ff;
   logic                    rsp_tvalid_ff;
   logic [39:0]             rsp_tdata_ff;

   logic                    req_fire, csr_fire;
   logic [SAMPLE_BITS-1:0]  in_sample, in_partner;
   logic [FIDX_BITS-1:0]    in_feature;
   logic [FEATURE_BITS-1:0] in_value;
   logic [COUNT_BITS-1:0]   count_in;
   logic [FEATURE_BITS-1:0] rd_a, rd_b;
   logic signed [16:0]      diff;
   logic [15:0]             mag;
   logic [59:0]             prod;
   logic [60:0]             acc_prod;
   logic [31:0]             rounded;
   logic                    out_free;

   assign in_sample  = req_tdata[7:0];
   assign in_feature = req_tdata[11:8];
   assign in_partner = req_tdata[19:12];
   assign in_value   = req_tdata[35:20];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign count_in = (fcount_ff > COUNT_BITS'(MAX_FEATURES)) ?
                     COUNT_BITS'(MAX_FEATURES) : fcount_ff;

   // Sample memory: loads write, the feature walk reads both samples.
   rbfk_store u_store (
      .clock     (clock),
      .wr_en     (req_fire && (req_tuser == ACT_LOAD)),
      .wr_addr   ({in_sample, in_feature}),
      .wr_data   (in_value),
      .rd_en     (state_ff == S_READ),
      .rd_addr_a ({row_ff, k_ff[FIDX_BITS-1:0]}),
      .rd_addr_b ({col_ff, k_ff[FIDX_BITS-1:0]}),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // Datapath terms.
   assign diff     = $signed({rd_a[15], rd_a}) - $signed({rd_b[15], rd_b});
   assign mag      = diff[16] ? 16'(-diff) : diff[15:0];
   assign prod     = {phi_ff, 18'd0} + {18'd0, plo_ff};
   assign acc_prod = (acc_ff * exp_bit(b_ff)) + 61'(1 << 29);
   assign rounded  = {1'b0, acc_ff} + 32'd8192;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff  <= 24'd65536;
         fcount_ff <= 5'd16;
      end else if (csr_fire) begin
         if (csr_index == CSR_GAMMA) begin
            gamma_ff <= csr_data;
         end else if (csr_index == CSR_FEATURE_COUNT) begin
            fcount_ff <= csr_data[COUNT_BITS-1:0];
         end
      end
   end

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         k_ff          <= '0;
      end else begin
         v1_ff <= (state_ff == S_READ);
         v2_ff <= v1_ff;
         // The result register fills from a finished pair and empties on a transfer.
         if ((state_ff == S_DONE) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire && (req_tuser == ACT_COMPUTE)) begin
                  row_ff   <= in_sample;
                  col_ff   <= in_partner;
                  count_ff <= count_in;
                  k_ff     <= '0;
                  state_ff <= (count_in == '0) ? S_DRAIN : S_READ;
               end
            end
            S_READ: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == count_ff - 1'b1) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!v1_ff && !v2_ff) begin
                  state_ff <= S_MUL_LO;
               end
            end
            S_MUL_LO: state_ff <= S_MUL_HI;
            S_MUL_HI: state_ff <= S_CHECK;
            S_CHECK:  state_ff <= S_EXP;
            S_EXP: begin
               if (b_ff == 5'd0) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_tdata_ff  <= {7'd0,
                                    big_ff ? 17'd0 : rounded[30:14],
                                    col_ff, row_ff};
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Distance sum, gamma scaling and exponent product.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sum_ff <= '0;
      end else if (v2_ff) begin
         sum_ff <= sum_ff + {4'd0, sq_ff};
      end
      if (v1_ff) begin
         sq_ff <= mag * mag;
      end
      case (state_ff)
         S_MUL_LO: plo_ff <= sum_ff[17:0] * gamma_ff;
         S_MUL_HI: phi_ff <= sum_ff[35:18] * gamma_ff;
         S_CHECK: begin
            big_ff <= (prod[59:34] >= 26'd3);
            x_ff   <= prod[35:16];
            acc_ff <= ONE_Q30;
            b_ff   <= 5'd19;
         end
         S_EXP: begin
            if (x_ff[b_ff]) begin
               acc_ff <= acc_prod[60:30];
            end
            b_ff <= b_ff - 1'b1;
         end
         default: ;
      endcase
   end

   // The feature walk never reads past the configured count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (k_ff < count_ff))
      else $error("feature walk past count");

   // The square pipeline is empty before gamma is applied.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_LO) |-> (!v1_ff && !v2_ff))
      else $error("sum taken before pipeline drained");

   // The exponent product never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXP) |-> (acc_ff <= ONE_Q30))
      else $error("exponent product above one");

   // A finished pair waits while the result register is occupied.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == S_DONE))
      else $error("result overwritten");

   // No pair is accepted while one is in work.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("input taken during pair");

endmodule

[hdl/rbfk_store.sv]
module rbfk_store (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [rbfk_pkg::ADDR_BITS-1:0]         wr_addr,
   input  logic [rbfk_pkg::FEATURE_BITS-1:0]      wr_data,
   input  logic                                   rd_en,
   input  logic [rbfk_pkg::ADDR_BITS-1:0]         rd_addr_a,
   input  logic [rbfk_pkg::ADDR_BITS-1:0]         rd_addr_b,
   output logic [rbfk_pkg::FEATURE_BITS-1:0]      rd_data_a,
   output logic [rbfk_pkg::FEATURE_BITS-1:0]      rd_data_b
);
   import rbfk_pkg::*;

   localparam int DEPTH = MAX_SAMPLES * MAX_FEATURES;

   logic [FEATURE_BITS-1:0] mem [DEPTH];

   // One write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

[test/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rbfk_pkg::*;

   // Kernel predictor table: exp(-2^(b-16)) in Q0.30.
   localparam logic [29:0] EXP_TABLE [20] = '{
      30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760,
      30'd1073479712, 30'd1073217664, 30'd1072693760, 30'd1071646719,
      30'd1069555701, 30'd1065385899, 30'd1057095000, 30'd1040706261,
      30'd1008687096, 30'd947573834,  30'd836230973,  30'd651257337,
      30'd395007542,  30'd145315154,  30'd19666268,   30'd360200
   };

   typedef struct packed {
      logic [7:0]  row;
      logic [7:0]  col;
      logic [16:0] kernel;
   } kernel_result_type;

   // Scoreboard: holds the shadow sample memory, the registers and the
   // queue of kernel results still owed by the block.
   class scoreboard_type;
      logic signed [15:0] features [MAX_SAMPLES*MAX_FEATURES];
      logic [23:0] gamma_q;
      logic [4:0]  count_q;
      kernel_result_type pending [$];
      int errors;
      int pairs_seen;
      int loads_seen;

      function new();
         gamma_q = 24'd65536;
         count_q = 5'd16;
         errors = 0;
         pairs_seen = 0;
         loads_seen = 0;
         foreach (features[i]) features[i] = '0;
      endfunction

      function void write_csr(logic [7:0] idx, logic [23:0] data);
         if (idx == CSR_GAMMA) gamma_q = data;
         else if (idx == CSR_FEATURE_COUNT) count_q = data[4:0];
      endfunction

      function logic [16:0] gaussian(logic [63:0] sq_sum);
         logic [63:0] prod;
         logic [63:0] arg;
         logic [63:0] acc;
         acc = 64'd1 << 30;
         prod = sq_sum * {40'd0, gamma_q};
         if (prod >= (64'd12 << 32)) return 17'd0;
         arg = prod >> 16;
         for (int b = 19; b >= 0; b--) begin
            if (arg[b]) acc = (acc * {34'd0, EXP_TABLE[b]} + (64'd1 << 29)) >> 30;
         end
         return 17'((acc + (64'd1 << 13)) >> 14);
      endfunction

      function void note_request(logic kind, logic [39:0] data);
         logic [7:0] row;
         logic [3:0] fidx;
         logic [7:0] col;
         logic signed [15:0] value;
         logic [63:0] sq_sum;
         logic signed [17:0] diff;
         logic signed [63:0] wide;
         int n;
         kernel_result_type res;
         row = data[7:0];
         fidx = data[11:8];
         col = data[19:12];
         value = data[35:20];
         if (kind == ACT_LOAD) begin
            features[row*MAX_FEATURES + fidx] = value;
            loads_seen++;
         end else begin
            n = (count_q > MAX_FEATURES) ? MAX_FEATURES : count_q;
            sq_sum = '0;
            for (int k = 0; k < n; k++) begin
               diff = features[row*MAX_FEATURES+k] - features[col*MAX_FEATURES+k];
               wide = 64'(diff);
               sq_sum = sq_sum + $unsigned(wide * wide);
            end
            res.row = row;
            res.col = col;
            res.kernel = gaussian(sq_sum);
            pending = {pending, res};
            pairs_seen++;
         end
      endfunction

      function void check_result(logic [39:0] data);
         kernel_result_type want;
         if (pending.size() == 0) begin
            $error("unexpected result tdata=%h", data);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (data[7:0] !== want.row) begin
            $error("row_out expected %0d actual %0d", want.row, data[7:0]);
            errors++;
         end
         if (data[15:8] !== want.col) begin
            $error("col_out expected %0d actual %0d", want.col, data[15:8]);
            errors++;
         end
         if (data[32:16] !== want.kernel) begin
            $error("kernel_value expected %0d actual %0d", want.kernel, data[32:16]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [39:0] req_tdata = '0;   // sample_index, feature_index, partner_index, feature_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // row_out, col_out, kernel_value
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   scoreboard_type board;
   bit rsp_random_stall = 1'b1;
   // Samples that hold all sixteen features, so pairs never read unwritten entries.
   logic [7:0] filled [$];
   bit is_filled [256];

   rbf_kernel_pair DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Result side: random stalls when enabled, checking at the rising edge.
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = rsp_random_stall ? $urandom_range(0, 15) : 0;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
         board.check_result(rsp_tdata);
         @(negedge clock);
      end
   end

   task automatic send_item(input logic kind, input logic [7:0] row, input logic [3:0] fidx,
                            input logic [7:0] col, input logic [15:0] value, input bit idle);
      int gap;
      gap = idle ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'd0, value, col, fidx, row};
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, {4'd0, value, col, fidx, row});
      @(negedge clock);
   endtask

   task automatic finish_items();
      req_tvalid <= 1'b0;
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [23:0] data);
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_csr(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic fill_sample(input logic [7:0] s, input bit extreme, input bit idle);
      for (int f = 0; f < MAX_FEATURES; f++) begin
         send_item(ACT_LOAD, s, 4'(f), 8'($urandom), extreme ? ((f % 2) ? 16'h8000 : 16'h7FFF)
                   : 16'($urandom), idle);
      end
      if (!is_filled[s]) begin
         is_filled[s] = 1'b1;
         filled = {filled, s};
      end
   endtask

   task automatic random_pairs(input int n);
      logic [7:0] a;
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         a = filled[$urandom_range(0, filled.size() - 1)];
         b = filled[$urandom_range(0, filled.size() - 1)];
         if ($urandom_range(0, 3) == 0) begin
            // Reload one random feature, half the time with a small value in 0 to 63.
            send_item(ACT_LOAD, a, 4'($urandom), 8'($urandom),
                      16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 63)), 1'b1);
         end
         send_item(ACT_COMPUTE, a, 4'($urandom), b, 16'($urandom), i % 64 < 48);
      end
   endtask

   initial begin
      int phase_pairs;
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extreme values, identical samples, small distances.
      fill_sample(8'd0, 1'b1, 1'b0);
      fill_sample(8'd255, 1'b1, 1'b0);
      send_item(ACT_COMPUTE, 8'd0, 4'd0, 8'd0, 16'd0, 1'b0);
      send_item(ACT_COMPUTE, 8'd0, 4'd15, 8'd255, 16'hFFFF, 1'b0);
      write_reg(CSR_GAMMA, 24'd0);
      send_item(ACT_COMPUTE, 8'd255, 4'd0, 8'd0, 16'd0, 1'b0);
      write_reg(CSR_GAMMA, 24'd1);
      write_reg(CSR_FEATURE_COUNT, 24'd1);
      send_item(ACT_LOAD, 8'd1, 4'd0, 8'd0, 16'h0001, 1'b0);
      send_item(ACT_LOAD, 8'd2, 4'd0, 8'd0, 16'h0000, 1'b0);
      send_item(ACT_COMPUTE, 8'd1, 4'd0, 8'd2, 16'd0, 1'b0);
      write_reg(CSR_GAMMA, 24'hFFFFFF);
      send_item(ACT_COMPUTE, 8'd1, 4'd0, 8'd2, 16'd0, 1'b0);
      write_reg(CSR_FEATURE_COUNT, 24'd0);
      send_item(ACT_COMPUTE, 8'd0, 4'd0, 8'd255, 16'd0, 1'b0);
      write_reg(CSR_FEATURE_COUNT, 24'd31);
      send_item(ACT_COMPUTE, 8'd0, 4'd0, 8'd255, 16'd0, 1'b0);

      // Random: several register settings, pairs among fully loaded samples.
      for (int s = 0; s < 12; s++) fill_sample(8'($urandom_range(1, 254)), 1'b0, 1'b1);
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: write_reg(CSR_GAMMA, 24'($urandom_range(0, 3)));
            1: write_reg(CSR_GAMMA, 24'($urandom_range(0, 255)));
            2: write_reg(CSR_GAMMA, 24'($urandom));
            default: write_reg(CSR_GAMMA, 24'hFFFFFF);
         endcase
         write_reg(CSR_FEATURE_COUNT, (p == 3) ? 24'd16 : 24'($urandom_range(0, 20)));
         rsp_random_stall = (p != 5);
         phase_pairs = 160;
         fill_sample(8'($urandom_range(0, 255)), 1'b0, p % 2 == 0);
         random_pairs(phase_pairs);
      end
      finish_items();

      while (board.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Covered %0d loads and %0d kernel pairs over several gamma and count settings.",
               board.loads_seen, board.pairs_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

[files.f]
hdl/rbfk_pkg.sv
hdl/rbfk_store.sv
hdl/rbf_kernel_pair.sv
test/tb_top.sv
